/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. Defining NO_ASSERTIONS removes them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define RTT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define RTT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define RTT_ASSERT(label, clk, rst, prop, msg)
`define RTT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

/* rtl/rtt_pkg.sv */
// ----------------------------------------------------------------------------
// Retransmit timer table package
// Types and fixed constants shared by the table modules.
// ----------------------------------------------------------------------------
package rtt_pkg;

  localparam int SEQ_W   = 8;
  localparam int TIME_W  = 16;
  localparam int CNT_W   = 5;
  localparam int STAT_W  = 3;

  localparam logic [CNT_W-1:0]  CNT_MAX       = 5'd31;
  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 16'd1000;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SWEEP  = 2'd2,
    OP_NONE   = 2'd3
  } rtt_op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_ADDED      = 3'd0,
    ST_DUPLICATE  = 3'd1,
    ST_FULL       = 3'd2,
    ST_REMOVED    = 3'd3,
    ST_NOT_FOUND  = 3'd4,
    ST_SWEEP_DONE = 3'd5
  } rtt_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_FINISH
  } rtt_state_t;

  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] start;
  } rtt_entry_t;

  // Port controls from the sequencer to the entry store.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_en;
  } rtt_store_ctl_t;

endpackage

/* rtl/rtt_store.sv */
// ----------------------------------------------------------------------------
// Retransmit timer entry store
// Entry memory with registered read, plus per-slot valid flags.
// ----------------------------------------------------------------------------
module rtt_store #(
  parameter int TABLE_DEPTH = 16,
  localparam int IW = $clog2(TABLE_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rtt_pkg::rtt_store_ctl_t ctl,
  input  logic [IW-1:0]         rd_idx,
  input  logic [IW-1:0]         wr_idx,
  input  logic [IW-1:0]         clr_idx,
  input  rtt_pkg::rtt_entry_t   wr_entry,
  output rtt_pkg::rtt_entry_t   rd_entry,
  output logic                  rd_live
);

  rtt_pkg::rtt_entry_t          mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]       valid;

  // Valid flags live in flops so that reset empties the table at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ctl.wr_en) begin
        valid[wr_idx] <= 1'b1;
      end
      if (ctl.clr_en) begin
        valid[clr_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
    if (ctl.rd_en) begin
      rd_entry <= mem[rd_idx];
      rd_live  <= valid[rd_idx];
    end
  end

endmodule

/* rtl/retransmit_timer_table_unit.sv */
// ----------------------------------------------------------------------------
// Retransmit timer table unit
// Bounded table of frame timers keyed by sequence number: add, remove, sweep.
// ----------------------------------------------------------------------------
// Every beat on the input channel is one command and yields exactly one result
// beat. Add stores a sequence number and its start time in the lowest free slot,
// answering duplicate when the number is already held and full when no slot is
// free. Remove clears the slot holding the given sequence number. Sweep clears
// every slot whose age, (time_value - start) modulo 2^16, is at or above
// timeout_ticks and reports how many it cleared, saturating at 31. Opcode 3
// changes nothing and answers not found. Every command walks the whole table
// through the single read port of the entry memory, one slot per cycle; from
// acceptance to a loaded result it passes through the accept step, one read per
// slot, the last read data and the finish step. One command is in work
// at a time; the next is accepted as soon as the result sits in the output
// register, even while that result is still stalled. timeout_ticks resets to
// 1000 and should only be written while the unit is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module retransmit_timer_table_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: timeout_ticks
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  // command channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [7:0]  seq_number,
  input  logic [15:0] time_value,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [4:0]  removed_count
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

  rtt_pkg::rtt_state_t      state, state_next;

  // Latched command.
  rtt_pkg::rtt_op_t         item_op;
  logic [rtt_pkg::SEQ_W-1:0]  item_seq;
  logic [rtt_pkg::TIME_W-1:0] item_time;
  logic [rtt_pkg::TIME_W-1:0] timeout;

  // Scan address and the read that is in flight.
  logic [IW-1:0]            idx;
  logic                     rd_pend;
  logic [IW-1:0]            proc_idx;

  // Scan findings.
  logic                     found;
  logic                     free_found;
  logic [IW-1:0]            free_idx;
  logic [rtt_pkg::CNT_W-1:0]  count;

  rtt_pkg::rtt_store_ctl_t  store_ctl;
  rtt_pkg::rtt_entry_t      wr_entry;
  rtt_pkg::rtt_entry_t      rd_entry;
  logic                     rd_live;

  logic                     accept;
  logic                     load;
  logic                     hit;
  logic                     expired;
  logic [rtt_pkg::TIME_W-1:0] age;
  rtt_pkg::rtt_status_t     res_status;
  logic [rtt_pkg::CNT_W-1:0]  res_count;

  assign in_stall = (state != rtt_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;

  // The result may leave the finish state once the output register is free
  // or is being emptied in this cycle.
  assign load = (state == rtt_pkg::S_FINISH) && (!out_valid || !out_stall);

  // Evaluation of the slot whose data came back from the memory this cycle.
  // A slot that is not live never matches and never expires.
  assign age     = item_time - rd_entry.start;
  assign hit     = rd_pend && rd_live && (rd_entry.seq == item_seq);
  assign expired = rd_pend && rd_live && (age >= timeout);

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= rtt_pkg::TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rtt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rtt_pkg::S_IDLE: begin
        if (accept) begin
          state_next = rtt_pkg::S_SCAN;
        end
      end
      rtt_pkg::S_SCAN: begin
        if (idx == LAST_IDX) begin
          state_next = rtt_pkg::S_LAST;
        end
      end
      rtt_pkg::S_LAST: begin
        state_next = rtt_pkg::S_FINISH;
      end
      rtt_pkg::S_FINISH: begin
        if (load) begin
          state_next = rtt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rtt_pkg::S_IDLE;
      end
    endcase
  end

  // Command latch and scan bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= (state == rtt_pkg::S_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_op    <= rtt_pkg::rtt_op_t'(opcode);
      item_seq   <= seq_number;
      item_time  <= time_value;
      idx        <= '0;
      found      <= 1'b0;
      free_found <= 1'b0;
      count      <= '0;
    end else begin
      if (state == rtt_pkg::S_SCAN) begin
        idx <= idx + IW'(1);
      end
      if (hit) begin
        found <= 1'b1;
      end
      // The first slot seen empty is the lowest free one.
      if (rd_pend && !rd_live && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= proc_idx;
      end
      if ((item_op == rtt_pkg::OP_SWEEP) && expired && (count != rtt_pkg::CNT_MAX)) begin
        count <= count + rtt_pkg::CNT_W'(1);
      end
    end
    proc_idx <= idx;
  end

  // Result of the finished scan.
  always_comb begin
    res_status = rtt_pkg::ST_NOT_FOUND;
    res_count  = '0;
    case (item_op)
      rtt_pkg::OP_ADD: begin
        if (found) begin
          res_status = rtt_pkg::ST_DUPLICATE;
        end else if (free_found) begin
          res_status = rtt_pkg::ST_ADDED;
        end else begin
          res_status = rtt_pkg::ST_FULL;
        end
      end
      rtt_pkg::OP_REMOVE: begin
        if (found) begin
          res_status = rtt_pkg::ST_REMOVED;
          res_count  = rtt_pkg::CNT_W'(1);
        end
      end
      rtt_pkg::OP_SWEEP: begin
        res_status = rtt_pkg::ST_SWEEP_DONE;
        res_count  = count;
      end
      default: begin
        res_status = rtt_pkg::ST_NOT_FOUND;
        res_count  = '0;
      end
    endcase
  end

  // Removes and sweeps clear slots as the scan passes them; an add writes
  // its slot once, when the result is loaded.
  always_comb begin
    store_ctl.rd_en  = (state == rtt_pkg::S_SCAN);
    store_ctl.clr_en = ((item_op == rtt_pkg::OP_REMOVE) && hit)
                    || ((item_op == rtt_pkg::OP_SWEEP) && expired);
    store_ctl.wr_en  = load && (item_op == rtt_pkg::OP_ADD) && !found && free_found;
    wr_entry.seq     = item_seq;
    wr_entry.start   = item_time;
  end

  rtt_store #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .ctl      (store_ctl),
    .rd_idx   (idx),
    .wr_idx   (free_idx),
    .clr_idx  (proc_idx),
    .wr_entry (wr_entry),
    .rd_entry (rd_entry),
    .rd_live  (rd_live)
  );

  // Output register: holds the result beat until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status        <= res_status;
      removed_count <= res_count;
    end
  end

  // A new result beat only ever comes from the finish state.
  `RTT_ASSERT(a_load_from_finish, clk, rst, $rose(out_valid) |-> $past(state) == rtt_pkg::S_FINISH, "result appeared outside finish")
  // Only a sweep can report more than one removed entry.
  `RTT_NEVER(a_count_non_sweep, clk, rst, out_valid && (status != rtt_pkg::ST_SWEEP_DONE) && (removed_count > 5'd1), "non-sweep result removed more than one entry")
  // Read data is only consumed in the cycle after a scan read was issued.
  `RTT_ASSERT(a_read_latency, clk, rst, rd_pend |-> $past(state) == rtt_pkg::S_SCAN, "read data without a scan read")
  // An add never writes a slot while the scan is still clearing slots.
  `RTT_NEVER(a_write_clear_overlap, clk, rst, store_ctl.wr_en && store_ctl.clr_en, "write and clear in the same cycle")

endmodule
